[sv/cubic_spline_sweep_eval_defines.svh]
// Assertion macros shared by the spline evaluator checker
`ifndef CUBIC_SPLINE_SWEEP_EVAL_DEFINES_SVH
`define CUBIC_SPLINE_SWEEP_EVAL_DEFINES_SVH

// Same-cycle implication
`define CSSE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spline evaluator check failed");

// Next-cycle implication
`define CSSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spline evaluator check failed");

`endif

[sv/csse_pkg.sv]
// Types, codes and helpers shared by the spline evaluator modules
`timescale 1ns / 1ps
package csse_pkg;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_EVAL    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [2:0] RD_ZERO     = 3'd0;
   localparam logic [2:0] RD_ONE      = 3'd1;
   localparam logic [2:0] RD_LAST     = 3'd2;
   localparam logic [2:0] RD_SEG_NEXT = 3'd3;
   localparam logic [2:0] RD_SEG      = 3'd4;

   localparam logic [1:0] STEP_CUBIC = 2'd0;
   localparam logic [1:0] STEP_QUAD  = 2'd1;
   localparam logic [1:0] STEP_LAST  = 2'd2;

   localparam logic REG_ROW_COUNT   = 1'b0;
   localparam logic REG_EXTRAP_ZERO = 1'b1;

   localparam int ROW_W = 160;

   localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
   localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

   typedef struct packed {
      logic signed [31:0] coef_cubic;
      logic signed [31:0] coef_quad;
      logic signed [31:0] coef_lin;
      logic signed [31:0] coef_const;
      logic signed [31:0] knot;
   } row_type;

   typedef struct packed {
      logic       accept_eval;
      logic       wr_en;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       restart;
      logic       cap_low;
      logic       check_range;
      logic       adv_step;
      logic       cap_diff;
      logic       mul;
      logic       add;
      logic [1:0] step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic outside;
      logic go_adv;
      logic adv_more;
      logic out_free;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[sv/csse_ram.sv]
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module csse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/csse_ctrl.sv]
// Sequencer for table writes, restarts and spline evaluations
`timescale 1ns / 1ps
module csse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_kind,
   output logic                   req_ready,
   output csse_pkg::cmd_type      cmd,
   input  csse_pkg::status_type   status
);
   import csse_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RESTART = 4'd1;
   localparam logic [3:0] S_LOW     = 4'd2;
   localparam logic [3:0] S_HIGH    = 4'd3;
   localparam logic [3:0] S_ADV     = 4'd4;
   localparam logic [3:0] S_ADV_CHK = 4'd5;
   localparam logic [3:0] S_FETCH   = 4'd6;
   localparam logic [3:0] S_DIFF    = 4'd7;
   localparam logic [3:0] S_MUL     = 4'd8;
   localparam logic [3:0] S_ADD     = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               priority if (req_kind == KIND_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else if (req_kind == KIND_RESTART) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_ONE;
                  state_in   = S_RESTART;
               end else if (req_kind == KIND_EVAL) begin
                  cmd.accept_eval = 1'b1;
                  cmd.rd_en       = 1'b1;
                  cmd.rd_sel      = RD_ZERO;
                  state_in        = S_LOW;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RESTART: begin
            cmd.restart = 1'b1;
            state_in    = S_IDLE;
         end
         S_LOW: begin
            cmd.cap_low = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_LAST;
            state_in    = S_HIGH;
         end
         S_HIGH: begin
            cmd.check_range = 1'b1;
            priority if (status.outside) begin
               state_in = S_DONE;
            end else if (status.go_adv) begin
               state_in = S_ADV;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_ADV: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SEG_NEXT;
            state_in   = S_ADV_CHK;
         end
         S_ADV_CHK: begin
            cmd.adv_step = 1'b1;
            state_in     = status.adv_more ? S_ADV : S_FETCH;
         end
         S_FETCH: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SEG;
            state_in   = S_DIFF;
         end
         S_DIFF: begin
            cmd.cap_diff = 1'b1;
            step_in      = STEP_CUBIC;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add = 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = S_DONE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_CUBIC;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[sv/csse_datapath.sv]
// Table memory, segment tracking, Horner arithmetic and result register
`timescale 1ns / 1ps
module csse_datapath #(
   parameter int ROWS      = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  csse_pkg::cmd_type     cmd,
   output csse_pkg::status_type  status,
   input  logic [5:0]            req_row_index,
   input  logic signed [31:0]    req_knot_x,
   input  logic signed [31:0]    req_coef_const,
   input  logic signed [31:0]    req_coef_lin,
   input  logic signed [31:0]    req_coef_quad,
   input  logic signed [31:0]    req_coef_cubic,
   input  logic signed [31:0]    req_sample_x,
   input  logic [6:0]            row_count,
   input  logic                  extrapolate_zero,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_y_value,
   output logic                  rsp_outside_range,
   output logic                  rsp_range_error,
   output logic [5:0]            rsp_segment_used
);
   import csse_pkg::*;

   localparam int AW = $clog2(ROWS);
   localparam int NW = $clog2(ROWS + 1);

   logic [NW-1:0]      n_used;
   logic [AW-1:0]      last_idx, last_seg;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic               wr_ok;
   row_type            wr_row, rd_row;
   logic [ROW_W-1:0]   rd_data;
   logic signed [31:0] rd_knot, upper_eff, mul_op, add_coef;
   logic               outside_now, stale, adv_more;
   logic signed [32:0] diff;
   logic signed [63:0] prod_in, shifted;
   logic signed [64:0] sum;

   logic signed [31:0] x_ff, upper_ff, upper_in, e_ff, t_ff;
   logic               below_ff, outside_ff;
   logic [AW-1:0]      seg_ff, seg_in;
   logic signed [63:0] prod_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_y_ff;
   logic               rsp_outside_ff, rsp_error_ff;
   logic [5:0]         rsp_seg_ff;

   always_comb begin
      if (32'(row_count) < 2) begin
         n_used = NW'(2);
      end else if (32'(row_count) > ROWS) begin
         n_used = NW'(ROWS);
      end else begin
         n_used = NW'(row_count);
      end
   end

   assign last_idx = AW'(n_used - NW'(1));
   assign last_seg = AW'(n_used - NW'(2));

   assign wr_ok   = cmd.wr_en && (32'(req_row_index) < ROWS);
   assign wr_addr = AW'(req_row_index);
   assign wr_row  = '{coef_cubic: req_coef_cubic, coef_quad: req_coef_quad,
                      coef_lin: req_coef_lin, coef_const: req_coef_const,
                      knot: req_knot_x};

   always_comb begin
      unique case (cmd.rd_sel)
         RD_ZERO:     rd_addr = '0;
         RD_ONE:      rd_addr = AW'(1);
         RD_LAST:     rd_addr = last_idx;
         RD_SEG_NEXT: rd_addr = seg_ff + AW'(1);
         RD_SEG:      rd_addr = seg_ff;
         default:     rd_addr = '0;
      endcase
   end

   csse_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_row  = row_type'(rd_data);
   assign rd_knot = rd_row.knot;

   assign outside_now = below_ff || (x_ff > rd_knot);
   assign stale       = seg_ff > last_seg;
   assign upper_eff   = stale ? rd_knot : upper_ff;
   assign adv_more    = (seg_ff < last_seg) && (rd_knot < x_ff);

   assign status.outside  = outside_now;
   assign status.go_adv   = upper_eff < x_ff;
   assign status.adv_more = adv_more;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign diff = 33'(x_ff) - 33'(rd_knot);

   assign mul_op  = (cmd.step == STEP_CUBIC) ? rd_row.coef_cubic : t_ff;
   assign prod_in = e_ff * mul_op;

   always_comb begin
      unique case (cmd.step)
         STEP_CUBIC: add_coef = rd_row.coef_quad;
         STEP_QUAD:  add_coef = rd_row.coef_lin;
         STEP_LAST:  add_coef = rd_row.coef_const;
         default:    add_coef = rd_row.coef_const;
      endcase
   end

   assign shifted = prod_ff >>> FRAC_BITS;
   assign sum     = 65'(add_coef) + 65'(shifted);

   always_comb begin
      seg_in   = seg_ff;
      upper_in = upper_ff;
      priority if (cmd.restart) begin
         seg_in   = '0;
         upper_in = rd_knot;
      end else if (cmd.check_range && !outside_now && stale) begin
         seg_in   = last_seg;
         upper_in = rd_knot;
      end else if (cmd.adv_step && adv_more) begin
         seg_in = seg_ff + AW'(1);
      end else if (cmd.adv_step) begin
         upper_in = rd_knot;
      end else begin
         seg_in = seg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= '0;
         upper_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff   <= seg_in;
         upper_ff <= upper_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_eval) begin
         x_ff <= req_sample_x;
      end
      if (cmd.cap_low) begin
         below_ff <= x_ff < rd_knot;
      end
      if (cmd.check_range) begin
         outside_ff <= outside_now;
         if (outside_now) begin
            t_ff <= '0;
         end
      end
      if (cmd.cap_diff) begin
         e_ff <= sat32(65'(diff));
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.add) begin
         t_ff <= sat32(sum);
      end
      if (cmd.out_load) begin
         rsp_y_ff       <= t_ff;
         rsp_outside_ff <= outside_ff;
         rsp_error_ff   <= outside_ff && !extrapolate_zero;
         rsp_seg_ff     <= 6'(seg_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_y_value       = rsp_y_ff;
   assign rsp_outside_range = rsp_outside_ff;
   assign rsp_range_error   = rsp_error_ff;
   assign rsp_segment_used  = rsp_seg_ff;

endmodule

[sv/cubic_spline_sweep_eval.sv]
// Top level of the piecewise cubic spline sweep evaluator
//
//   channel   direction   handshake                 payload
//   req       in          req_tvalid / req_tready   tuser kind, tdata row and sample
//   rsp       out         rsp_tvalid / rsp_tready   tuser flags, tdata value and segment
//   csr       in          APB-style, pready high    row_count, extrapolate_zero
//
// An evaluation reads the first and last knots for the range check, advances one segment
// at a time while the next knot is below the sample, fetches the segment row and runs
// three dependent Horner steps on the one shared multiplier; a sample outside the knots
// skips to the result. The registered memory read delivers one row per cycle.
// Reset is synchronous; it clears segment, upper knot, extrapolate_zero and result valid.
// A pending result waits in the output register; the next request is taken meanwhile
// and its result stalls until the register frees.
`timescale 1ns / 1ps
module cubic_spline_sweep_eval #(
   parameter int ROWS      = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [5:0] row_index, [37:6] knot_x, [69:38] coef_const, [101:70] coef_lin,
   // [133:102] coef_quad, [165:134] coef_cubic, [197:166] sample_x, [199:198] zero
   input  logic [199:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] y_value, [37:32] segment_used, [39:38] zero
   output logic [39:0]  rsp_tdata,
   // [0] outside_range, [1] range_error
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import csse_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [6:0]         row_count_ff;
   logic               extrap_zero_ff;
   logic               csr_wr;
   logic signed [31:0] y_value;
   logic               outside_range, range_error;
   logic [5:0]         segment_used;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= 7'd2;
         extrap_zero_ff <= 1'b0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_ROW_COUNT) begin
            row_count_ff <= csr_pwdata[6:0];
         end else begin
            extrap_zero_ff <= csr_pwdata[0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_EXTRAP_ZERO) ? {31'd0, extrap_zero_ff}
                                                         : {25'd0, row_count_ff};

   csse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   csse_datapath #(
      .ROWS      (ROWS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_row_index     (req_tdata[5:0]),
      .req_knot_x        (req_tdata[37:6]),
      .req_coef_const    (req_tdata[69:38]),
      .req_coef_lin      (req_tdata[101:70]),
      .req_coef_quad     (req_tdata[133:102]),
      .req_coef_cubic    (req_tdata[165:134]),
      .req_sample_x      (req_tdata[197:166]),
      .row_count         (row_count_ff),
      .extrapolate_zero  (extrap_zero_ff),
      .rsp_ready         (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_y_value       (y_value),
      .rsp_outside_range (outside_range),
      .rsp_range_error   (range_error),
      .rsp_segment_used  (segment_used)
   );

   assign rsp_tdata = {2'b00, segment_used, y_value};
   assign rsp_tuser = {range_error, outside_range};

endmodule

[sv/csse_checker.sv]
// Port-level checks on the spline evaluator result channel
`timescale 1ns / 1ps
`include "cubic_spline_sweep_eval_defines.svh"
module csse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   `CSSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `CSSE_ASSERT_IMPL(a_error_needs_outside, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0])
   `CSSE_ASSERT_IMPL(a_outside_gives_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[31:0] == 32'd0)
   `CSSE_ASSERT_NEXT(a_reset_clears_valid, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind cubic_spline_sweep_eval csse_checker u_csse_checker (.*);

[dv/cubic_spline_sweep_eval_test.sv]
// Self-checking testbench for the cubic spline sweep evaluator: scoreboard class and drive tasks
`timescale 1ns / 1ps
module cubic_spline_sweep_eval_test;
   import csse_pkg::*;

   localparam int TABLE_ROWS = 64;
   localparam int FRAC = 16;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int SETTLE = 200;
   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_ITEMS = 20;
   localparam int PHASES = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int Q_MAX = 32'sh7fff_ffff;
   localparam int Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [31:0] y_value;
      logic [5:0]  segment;
      logic        outside;
      logic        error;
   } spline_result_type;

   class spline_scoreboard;
      logic signed [31:0] knot [TABLE_ROWS];
      logic signed [31:0] c0 [TABLE_ROWS];
      logic signed [31:0] c1 [TABLE_ROWS];
      logic signed [31:0] c2 [TABLE_ROWS];
      logic signed [31:0] c3 [TABLE_ROWS];
      logic signed [31:0] upper_knot;
      int                 segment;
      logic [6:0]         row_count;
      logic               zero_outside;
      spline_result_type  due [$];
      int                 errors;
      int                 evals;
      int                 outside_seen;

      function new();
         upper_knot = '0;
         segment = 0;
         row_count = 7'd2;
         zero_outside = 1'b0;
         errors = 0;
         evals = 0;
         outside_seen = 0;
      endfunction

      function void set_reg(input logic idx, input logic [31:0] value);
         if (idx == REG_ROW_COUNT) begin
            row_count = value[6:0];
         end else begin
            zero_outside = value[0];
         end
      endfunction

      function logic signed [31:0] clip(input longint v);
         if (v > 64'sd2147483647) return 32'sh7fff_ffff;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function logic signed [31:0] fold(input logic signed [31:0] c, e, t);
         longint prod;
         prod = (longint'(e) * longint'(t)) >>> FRAC;
         return clip(longint'(c) + prod);
      endfunction

      function void note_request(input logic [1:0] kind, input logic [5:0] row,
                                 input logic signed [31:0] k, a, b, c, d, x);
         int n;
         int last;
         logic signed [31:0] e;
         logic signed [31:0] t;
         spline_result_type r;
         case (kind)
            KIND_WRITE: begin
               knot[row] = k;
               c0[row] = a;
               c1[row] = b;
               c2[row] = c;
               c3[row] = d;
            end
            KIND_RESTART: begin
               segment = 0;
               upper_knot = knot[1];
            end
            KIND_EVAL: begin
               n = row_count;
               if (n < 2) n = 2;
               if (n > TABLE_ROWS) n = TABLE_ROWS;
               last = n - 2;
               r.outside = (x < knot[0]) || (knot[n - 1] < x);
               r.error = r.outside && !zero_outside;
               r.y_value = '0;
               if (!r.outside) begin
                  if (segment > last) begin
                     segment = last;
                     upper_knot = knot[last + 1];
                  end
                  if (upper_knot < x) begin
                     while (segment < last && knot[segment + 1] < x) segment++;
                     upper_knot = knot[segment + 1];
                  end
                  e = clip(longint'(x) - longint'(knot[segment]));
                  t = fold(c2[segment], e, c3[segment]);
                  t = fold(c1[segment], e, t);
                  r.y_value = fold(c0[segment], e, t);
               end
               r.segment = 6'(segment);
               evals++;
               if (r.outside) outside_seen++;
               due.push_back(r);
            end
            default: ;
         endcase
      endfunction

      task report(input string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_result(input logic [31:0] y, input logic [5:0] seg,
                        input logic outside, input logic error);
         spline_result_type want;
         if (due.size() == 0) begin
            report($sformatf("result y=%h seg=%0d with no request pending", y, seg));
            return;
         end
         want = due.pop_front();
         if (y !== want.y_value)
            report($sformatf("y_value %h, want %h", y, want.y_value));
         if (seg !== want.segment)
            report($sformatf("segment_used %0d, want %0d", seg, want.segment));
         if (outside !== want.outside)
            report($sformatf("outside_range %b, want %b", outside, want.outside));
         if (error !== want.error)
            report($sformatf("range_error %b, want %b", error, want.error));
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   spline_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   int hold_left = 0;
   int requests = 0;
   int phase_rows [PHASES] = '{64, 2, 127, 1, 17, 0, 65, 33};

   cubic_spline_sweep_eval dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send(input logic [1:0] kind, input logic [5:0] row,
                       input int k, a, b, c, d, x);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, x, d, c, b, a, k, row};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, row, k, a, b, c, d, x);
      if (kind != KIND_UNUSED) requests++;
   endtask

   task automatic evaluate(input int x);
      send(KIND_EVAL, 6'($urandom), int'($urandom), int'($urandom), int'($urandom),
           int'($urandom), int'($urandom), x);
   endtask

   task automatic restart_sweep();
      send(KIND_RESTART, 6'($urandom), int'($urandom), int'($urandom), int'($urandom),
           int'($urandom), int'($urandom), int'($urandom));
   endtask

   task automatic write_row(input int row, k, a, b, c, d);
      send(KIND_WRITE, 6'(row), k, a, b, c, d, int'($urandom));
   endtask

   function automatic int rand_coef();
      if ($urandom_range(7) == 0) return int'($urandom);
      return int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
   endfunction

   task automatic load_table(input int n);
      int k;
      k = int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
      for (int i = 0; i < n; i++) begin
         write_row(i, k, rand_coef(), rand_coef(), rand_coef(), rand_coef());
         if ($urandom_range(9) != 0) k += int'($urandom_range(1, 32'h4_0000));
      end
   endtask

   task automatic sweep(input int n, input bit fresh);
      longint lo;
      longint hi;
      longint span;
      longint pos;
      longint stride;
      int cnt;
      int row;
      if (fresh) restart_sweep();
      lo = sb.knot[0];
      hi = sb.knot[n - 1];
      span = (hi > lo) ? hi - lo : 64'd65536;
      cnt = $urandom_range(3, 12);
      stride = span * 5 / (4 * cnt) + 1;
      pos = lo;
      if ($urandom_range(3) == 0) pos -= longint'($urandom) % (span / 8 + 1);
      repeat (cnt) begin
         case ($urandom_range(24))
            0: send(KIND_UNUSED, 6'($urandom), int'($urandom), int'($urandom),
                    int'($urandom), int'($urandom), int'($urandom), int'($urandom));
            1: evaluate(int'($urandom));
            2: begin
               row = $urandom_range(TABLE_ROWS - 1);
               write_row(row, ($urandom_range(2) == 0) ? int'($urandom) : int'(sb.knot[row]),
                         int'($urandom), rand_coef(), rand_coef(), rand_coef());
            end
            3: evaluate(sb.clip(pos - longint'($urandom) % stride));
            default: begin
               if ($urandom_range(9) != 0) pos += longint'($urandom) % stride;
               if ($urandom_range(7) == 0) begin
                  row = $urandom_range(n - 1);
                  if (sb.knot[row] > pos) pos = sb.knot[row];
               end
               evaluate(sb.clip(pos));
            end
         endcase
      end
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[31:0], rsp_tdata[37:32], rsp_tuser[0], rsp_tuser[1]);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            stalled = 0;
         else
            stalled++;
      end
      $display("No handshake for %0d cycles, run abandoned", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int n;
      int start;
      bit fresh;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      load_table(TABLE_ROWS);

      // two knots, range errors on
      send(KIND_UNUSED, 6'($urandom), int'($urandom), int'($urandom), int'($urandom),
           int'($urandom), int'($urandom), int'($urandom));
      evaluate(sb.knot[0]);
      restart_sweep();
      evaluate(sb.knot[1]);
      evaluate(sb.knot[1] + 1);
      evaluate(sb.knot[0] - 1);
      evaluate(Q_MIN);
      evaluate(Q_MAX);

      // full table, silent zero outside
      quiesce();
      csr_write(REG_ROW_COUNT, 32'd64);
      csr_write(REG_EXTRAP_ZERO, 32'd1);
      restart_sweep();
      evaluate(sb.knot[0]);
      evaluate(sb.knot[40] + 1);
      evaluate(sb.knot[63]);
      evaluate(sb.knot[63] + 1);
      evaluate(sb.knot[20]);
      write_row(62, sb.knot[62], Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      evaluate(sb.knot[63]);

      // shrink table under a high segment, then extreme knots
      quiesce();
      csr_write(REG_ROW_COUNT, 32'd10);
      csr_write(REG_EXTRAP_ZERO, 32'd0);
      write_row(8, sb.knot[8], Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      evaluate(sb.knot[9]);
      write_row(0, Q_MIN, rand_coef(), rand_coef(), rand_coef(), rand_coef());
      write_row(1, Q_MAX, rand_coef(), rand_coef(), rand_coef(), rand_coef());
      write_row(9, Q_MAX, rand_coef(), rand_coef(), rand_coef(), rand_coef());
      restart_sweep();
      evaluate(Q_MAX);
      evaluate(Q_MIN);

      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         csr_write(REG_ROW_COUNT, 32'(phase_rows[p]) | ($urandom << 7));
         csr_write(REG_EXTRAP_ZERO, 32'(p % 2) | ($urandom << 1));
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 70; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 70; end
            default: begin send_idle = 6; recv_stall = 6; end
         endcase
         n = phase_rows[p];
         if (n < 2) n = 2;
         if (n > TABLE_ROWS) n = TABLE_ROWS;
         if (p == 0 || $urandom_range(1) == 0) load_table(n);
         // hold the result side so requests back up
         if (p == 2) hold_left = HOLD_CYCLES;
         fresh = (p == 0) || ($urandom_range(1) == 0);
         start = requests;
         while (requests - start < PHASE_ITEMS) begin
            sweep(n, fresh);
            fresh = 1'b1;
         end
      end

      quiesce();
      $display("Run covered %0d requests and %0d evaluations, %0d of them outside the table,",
               requests, sb.evals, sb.outside_seen);
      $display("over %0d register settings with idle, stall and back-pressure phases",
               PHASES + 3);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
